FILE: rtl/dpt_pkg.sv
package dpt_pkg;

  localparam logic [63:0] BITS_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BITS_DMAX = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BITS_DMIN = 64'h0010_0000_0000_0000;

  localparam int          MAX_DEC_EXP = 308;
  localparam int          MIN_DEC_EXP = -307;
  localparam int          MAG_W       = 9;    // magnitudes up to 308
  localparam int          CHUNK_W     = 14;   // multiplier digit width
  localparam int          NUM_CHUNKS  = 4;    // 4 x 14 covers 53 bits
  localparam int          QUO_BITS    = 54;   // 53 mantissa bits + guard

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_MUL,
    S_MRND,
    S_DINIT,
    S_DIV,
    S_DRND,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_ONE,
    LD_MAX,
    LD_MIN
  } load_t;

  typedef struct packed {
    load_t       ld;
    logic        mul_clear;
    logic        mul_step;
    logic [1:0]  chunk;
    logic        mul_round;
    logic [2:0]  kidx;
    logic        div_init;
    logic        div_step;
    logic        div_round;
    logic        out_load;
    logic        clip;
  } dp_cmd_t;

  // Table walk: 10^32, 10^16, 10^8, 10^4, 10^2, 10
  function automatic logic [MAG_W-1:0] step_exp(input logic [2:0] k);
    logic [MAG_W-1:0] r;
    case (k)
      3'd0:    r = 9'd32;
      3'd1:    r = 9'd16;
      3'd2:    r = 9'd8;
      3'd3:    r = 9'd4;
      3'd4:    r = 9'd2;
      default: r = 9'd1;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] step_val(input logic [2:0] k);
    logic [63:0] r;
    case (k)
      3'd0:    r = 64'h4693_B8B5_B505_6E17;
      3'd1:    r = 64'h4341_C379_37E0_8000;
      3'd2:    r = 64'h4197_D784_0000_0000;
      3'd3:    r = 64'h40C3_8800_0000_0000;
      3'd4:    r = 64'h4059_0000_0000_0000;
      default: r = 64'h4024_0000_0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/dpt_ctrl.sv
module dpt_ctrl
  import dpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] exponent,
  output logic        out_tvalid,
  input  logic        out_tready,
  output dp_cmd_t     cmd
);

  state_t           state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             clip_r, clip_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [15:0] e_s;
  logic [15:0]        e_abs;

  assign e_s        = signed'(exponent);
  assign e_abs      = e_s[15] ? (16'd0 - exponent) : exponent;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.ld        = LD_NONE;
    cmd.kidx      = k_r;
    cmd.chunk     = cnt_r[1:0];
    cmd.clip      = clip_r;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (e_s == 16'sd0) begin
            cmd.ld    = LD_ONE;
            clip_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (e_s > 16'(MAX_DEC_EXP)) begin
            cmd.ld    = LD_MAX;
            clip_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else if (e_s < 16'(MIN_DEC_EXP)) begin
            cmd.ld    = LD_MIN;
            clip_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.ld    = LD_ONE;
            clip_nxt  = 1'b0;
            mag_nxt   = e_abs[MAG_W-1:0];
            neg_nxt   = e_s[15];
            k_nxt     = '0;
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (mag_r == '0) begin
          state_nxt = neg_r ? S_DINIT : S_DONE;
        end else if (mag_r >= step_exp(k_r)) begin
          mag_nxt       = mag_r - step_exp(k_r);
          cnt_nxt       = '0;
          cmd.mul_clear = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_CHUNKS - 1)) begin
          state_nxt = S_MRND;
        end
      end
      S_MRND: begin
        cmd.mul_round = 1'b1;
        state_nxt     = S_NEXT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(QUO_BITS - 1)) begin
          state_nxt = S_DRND;
        end
      end
      S_DRND: begin
        cmd.div_round = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/dpt_dp.sv
module dpt_dp
  import dpt_pkg::*;
(
  input  logic        clk,
  input  dp_cmd_t     cmd,
  output logic [63:0] result_bits,
  output logic        clipped
);

  logic [63:0]  f_r;
  logic [111:0] acc_r;
  logic [54:0]  rem_r;
  logic [53:0]  q_r;
  logic [11:0]  dexp_r;
  logic [63:0]  out_bits_r;
  logic         clip_r;

  logic [52:0]  a_m;
  logic [63:0]  b_val;
  logic [55:0]  b_pad;
  logic [CHUNK_W-1:0] b_chunk;
  logic [66:0]  pp;
  logic [11:0]  esum;
  logic [63:0]  mul_res;
  logic [63:0]  div_res;
  logic         ge;
  logic [54:0]  diff;

  // round to nearest even, renormalize on carry out
  function automatic logic [63:0] pack_rne(input logic [52:0] m, input logic g,
                                           input logic s, input logic [11:0] e);
    logic [53:0] r;
    logic [11:0] ee;
    r  = {1'b0, m} + 54'(g & (s | m[0]));
    ee = e;
    if (r[53]) begin
      r  = r >> 1;
      ee = e + 12'd1;
    end
    return {1'b0, ee[10:0], r[51:0]};
  endfunction

  assign a_m     = {1'b1, f_r[51:0]};
  assign b_val   = step_val(cmd.kidx);
  assign b_pad   = {3'b0, 1'b1, b_val[51:0]};
  assign b_chunk = b_pad[CHUNK_W*cmd.chunk +: CHUNK_W];
  assign pp      = 67'(a_m) * 67'(b_chunk);
  assign esum    = {1'b0, f_r[62:52]} + {1'b0, b_val[62:52]} - 12'd1023;

  always_comb begin
    if (acc_r[105]) begin
      mul_res = pack_rne(acc_r[105:53], acc_r[52], |acc_r[51:0], esum + 12'd1);
    end else begin
      mul_res = pack_rne(acc_r[104:52], acc_r[51], |acc_r[50:0], esum);
    end
  end

  assign div_res     = pack_rne(q_r[53:1], q_r[0], rem_r != '0, dexp_r);
  assign ge          = rem_r >= {2'b0, a_m};
  assign diff        = rem_r - {2'b0, a_m};
  assign result_bits = out_bits_r;
  assign clipped     = clip_r;

  always_ff @(posedge clk) begin
    case (cmd.ld)
      LD_ONE:  f_r <= BITS_ONE;
      LD_MAX:  f_r <= BITS_DMAX;
      LD_MIN:  f_r <= BITS_DMIN;
      default: begin
        if (cmd.mul_round) begin
          f_r <= mul_res;
        end else if (cmd.div_round) begin
          f_r <= div_res;
        end
      end
    endcase

    if (cmd.mul_clear) begin
      acc_r <= '0;
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + (112'(pp) << (CHUNK_W * cmd.chunk));
    end

    // 1/f: dividend 1.0, pre-doubled when f's mantissa exceeds 1.0
    if (cmd.div_init) begin
      rem_r  <= (f_r[51:0] != '0) ? (55'd1 << 53) : (55'd1 << 52);
      dexp_r <= ((f_r[51:0] != '0) ? 12'd2045 : 12'd2046) - {1'b0, f_r[62:52]};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= (ge ? diff : rem_r) << 1;
      q_r   <= {q_r[52:0], ge};
    end

    if (cmd.out_load) begin
      out_bits_r <= f_r;
      clip_r     <= cmd.clip;
    end
  end

endmodule

FILE: rtl/double_power_of_ten.sv
// Sequence: a zero or clipped exponent goes from S_IDLE straight to S_DONE;
//   otherwise the table walk (at most 6 entries) runs S_MUL and S_MRND for each
//   multiply (up to 13), then S_DINIT, S_DIV and S_DRND for a negative exponent.
// Requests: one at a time; the iterative 53x14 multiplier and the
//   one-bit-per-cycle restoring divider work on each. A finished result waits
//   in the output register while the next request is already being worked on.
// Reset: rst_n synchronous, active low; clears controller and output valid.
module double_power_of_ten
  import dpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] exponent (signed)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] result_bits
  output logic [0:0]  out_tuser   // [0] clipped
);

  dp_cmd_t cmd;
  logic    clipped;

  // Controller: exponent range checks, greedy walk over the power table,
  // sequencing of multiply chunks, rounding and divide iterations.
  dpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .exponent   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Datapath: running double, shared mantissa multiplier, reciprocal divider,
  // result register.
  dpt_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .result_bits (out_tdata),
    .clipped     (clipped)
  );

  assign out_tuser = clipped;

endmodule

FILE: verif/tb_double_power_of_ten.sv
module tb_double_power_of_ten;
  import dpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] bits;
    logic        clipped;
  } pow_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] exponent (signed)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] result_bits
  logic [0:0]  out_tuser;       // [0] clipped

  pow_result_t pending_pows[$];
  int          errors = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          clip_requests = 0;
  int          sink_stall = 0;

  always #5 clk = ~clk;

  double_power_of_ten DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Ten to the exponent: clip outside -307..308, else greedy walk over the
  // power table with binary64 multiplies (RNE), reciprocal for negatives.
  function automatic pow_result_t pow10_of(input logic signed [15:0] exp_in);
    pow_result_t r;
    int          e;
    int          mag;
    real         f;
    int          step_e[6];
    real         step_r[6];
    step_e = '{32, 16, 8, 4, 2, 1};
    step_r = '{1.0e32, 1.0e16, 1.0e8, 1.0e4, 1.0e2, 10.0};
    e = exp_in;
    r.clipped = 1'b0;
    if (e == 0) begin
      r.bits = BITS_ONE;
    end else if (e > MAX_DEC_EXP) begin
      r.bits = BITS_DMAX;
      r.clipped = 1'b1;
    end else if (e < MIN_DEC_EXP) begin
      r.bits = BITS_DMIN;
      r.clipped = 1'b1;
    end else begin
      mag = (e < 0) ? -e : e;
      f = 1.0;
      for (int k = 0; k < 6; k++) begin
        while (mag >= step_e[k]) begin
          f = f * step_r[k];
          mag -= step_e[k];
        end
      end
      if (e < 0) f = 1.0 / f;
      r.bits = $realtobits(f);
    end
    return r;
  endfunction

  // One request; valid stays high across back-to-back requests.
  task automatic send_exponent(input logic [15:0] e);
    int gap;
    gap = $urandom_range(6);
    if ($urandom_range(3) == 0) gap = 0;  // stretches with no idling
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= e;
    do @(posedge clk); while (!in_tready);
    pending_pows.push_back(pow10_of(e));
    requests_sent++;
    if (pending_pows[$].clipped) clip_requests++;
  endtask

  // Result checker plus random backpressure, one out_tready update per edge.
  always @(posedge clk) begin
    pow_result_t exp_r;
    int          stall_next;
    stall_next = sink_stall;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_pows.size() == 0) begin
        $display("%0t: unexpected result bits=%h clipped=%b", $time, out_tdata,
                 out_tuser[0]);
        errors++;
      end else begin
        exp_r = pending_pows.pop_front();
        if (out_tdata !== exp_r.bits) begin
          $display("%0t: result_bits expected %h actual %h", $time, exp_r.bits,
                   out_tdata);
          errors++;
        end
        if (out_tuser[0] !== exp_r.clipped) begin
          $display("%0t: clipped expected %b actual %b", $time, exp_r.clipped,
                   out_tuser[0]);
          errors++;
        end
      end
      stall_next = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
    end
    if (stall_next > 0) begin
      sink_stall <= stall_next - 1;
      out_tready <= 1'b0;
    end else begin
      sink_stall <= 0;
      out_tready <= rst_n;
    end
  end

  // Zero, both clip edges, field extremes, every table entry and repeats.
  task automatic test_directed();
    int vals[$];
    vals = '{0, 1, -1, 308, 309, -307, -308, 32767, -32768, 32, -32, 33,
             64, -64, 16, 8, 4, 2, -2, 300, -300, 255, -256, 63, -127};
    foreach (vals[i]) send_exponent(16'(vals[i]));
  endtask

  // In-range exponents, where the multiply chain actually runs.
  task automatic test_random_in_range();
    repeat (400) send_exponent(16'($urandom_range(615) - 307));
  endtask

  // Whole 16-bit field plus the neighborhood of each clip boundary.
  task automatic test_random_full_field();
    repeat (150) begin
      case ($urandom_range(2))
        0:       send_exponent(16'($urandom));
        1:       send_exponent(16'(308 + $urandom_range(8) - 4));
        default: send_exponent(16'(-307 + $urandom_range(8) - 4));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_in_range();
    test_random_full_field();
    in_tvalid <= 1'b0;
    while (pending_pows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d exponent requests (%0d clipped), %0d results checked",
             requests_sent, clip_requests, results_seen);
    if (errors == 0) begin
      $display("double_power_of_ten verification clean");
    end else begin
      $display("double_power_of_ten verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_pows.size());
    $display("double_power_of_ten verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dpt_pkg.sv
rtl/dpt_ctrl.sv
rtl/dpt_dp.sv
rtl/double_power_of_ten.sv
verif/tb_double_power_of_ten.sv
